@@ design/interval_set_merge_split_defines.svh @@
// Assertion macros shared by the checker of the interval set block.
`ifndef INTERVAL_SET_MERGE_SPLIT_DEFINES_SVH
`define INTERVAL_SET_MERGE_SPLIT_DEFINES_SVH

// Same-cycle implication, sampled on i_clk and disabled during reset.
`define ISMS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("interval set check failed");

// Next-cycle implication, sampled on i_clk and disabled during reset.
`define ISMS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("interval set check failed");

`endif

@@ design/isms_pkg.sv @@
// Package with codes, states and control structs of the interval set block.
`timescale 1ns / 1ps
`default_nettype none
package isms_pkg;

    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_DUMP   = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_ABSENT = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_RUN,
        S_FLUSH,
        S_DUMP,
        S_RESP
    } t_state;

    typedef struct packed {
        logic pop;
        logic push;
    } t_cell_ctl;

    typedef struct packed {
        logic load;
        logic load_valid;
        logic scan;
        logic step;
        logic flush;
        logic full;
    } t_stream_ctl;

    typedef struct packed {
        logic found;
        logic split_full;
        logic hit;
    } t_stream_st;

endpackage
`default_nettype wire

@@ design/isms_if.sv @@
// Valid/ready channel interfaces for commands and results.
`timescale 1ns / 1ps
`default_nettype none
interface isms_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [15:0] bound_a;
    logic [15:0] bound_b;
    logic [15:0] point_value;

    modport source (output valid, output mode, output bound_a, output bound_b,
                    output point_value, input ready);
    modport sink (input valid, input mode, input bound_a, input bound_b,
                  input point_value, output ready);
endinterface

interface isms_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [4:0]  entry_count;
    logic [15:0] out_start;
    logic [16:0] out_end;
    logic        out_valid;
    logic        last;

    modport source (output valid, output status, output entry_count, output out_start,
                    output out_end, output out_valid, output last, input ready);
    modport sink (input valid, input status, input entry_count, input out_start,
                  input out_end, input out_valid, input last, output ready);
endinterface
`default_nettype wire

@@ design/interval_set_merge_split.sv @@
// Top level of the sorted disjoint range set: cell row, edit unit and sequencer.
//
//   channel   dir   handshake     payload
//   i_cmd     in    valid/ready   mode, bound_a, bound_b, point_value
//   o_res     out   valid/ready   status, entry_count, out_start, out_end, out_valid, last
//
// Add and remove rotate the n stored ranges once through the edit unit at the
// head of the cell row. An add on a full table first rotates once to look for
// an overlap and, when none is found, answers full without a second pass. Dump
// rotates the ranges past the head, one result each; empty dump and spare mode
// give one result. Reset empties the table; stored ranges need no clearing.
// A waiting result holds back the final response and each dump step.
`timescale 1ns / 1ps
`default_nettype none
module interval_set_merge_split #(
    parameter int MAX_RANGES = 16,
    parameter int CODE_BITS  = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    isms_cmd_if.sink    i_cmd,
    isms_res_if.source  o_res
);
    import isms_pkg::*;

    localparam int CNT_W = $clog2(MAX_RANGES + 1);
    localparam int IDX_W = $clog2(MAX_RANGES);

    t_state            r_state, n_state;
    logic [1:0]        r_mode;
    logic [CNT_W-1:0]  r_cnt, r_rd, r_occ, r_wr;
    logic [1:0]        r_status;
    logic              r_ov;
    logic [1:0]        r_o_status;
    logic [4:0]        r_o_count;
    logic [15:0]       r_o_s;
    logic [16:0]       r_o_e;
    logic              r_o_rv;
    logic              r_o_last;

    logic [CODE_BITS-1:0] cell_s [MAX_RANGES];
    logic [CODE_BITS:0]   cell_e [MAX_RANGES];

    t_cell_ctl            cctl;
    t_stream_ctl          sctl;
    t_stream_st           sst;
    logic                 emit;
    logic [CODE_BITS-1:0] emit_s, wr_s;
    logic [CODE_BITS:0]   emit_e, wr_e;
    logic [CNT_W-1:0]     wr_pos;
    logic                 accept, slot_free, out_load, last_rd, tbl_full;
    logic [CODE_BITS-1:0] cmd_a, cmd_b, ld_lo, cmd_pt;
    logic [CODE_BITS:0]   ld_hi;

    assign accept    = i_cmd.valid && i_cmd.ready;
    assign slot_free = !r_ov || o_res.ready;
    assign last_rd   = (r_rd == CNT_W'(1));
    assign tbl_full  = (r_cnt == CNT_W'(MAX_RANGES));

    assign cmd_a  = CODE_BITS'(i_cmd.bound_a);
    assign cmd_b  = CODE_BITS'(i_cmd.bound_b);
    assign cmd_pt = CODE_BITS'(i_cmd.point_value);
    assign ld_lo  = (cmd_a < cmd_b) ? cmd_a : cmd_b;
    assign ld_hi  = {1'b0, (cmd_a < cmd_b) ? cmd_b : cmd_a} + 1'b1;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_cmd.mode)
                        MODE_ADD: begin
                            if (r_cnt == '0) begin
                                n_state = S_FLUSH;
                            end else if (tbl_full) begin
                                n_state = S_SCAN;
                            end else begin
                                n_state = S_RUN;
                            end
                        end
                        MODE_REMOVE: n_state = (r_cnt == '0) ? S_FLUSH : S_RUN;
                        MODE_DUMP:   n_state = (r_cnt == '0) ? S_RESP : S_DUMP;
                        default:     n_state = S_RESP;
                    endcase
                end
            end
            S_SCAN: begin
                if (last_rd) begin
                    n_state = sst.hit ? S_RUN : S_RESP;
                end
            end
            S_RUN: begin
                if (last_rd) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: n_state = S_RESP;
            S_DUMP: begin
                if (slot_free && last_rd) begin
                    n_state = S_IDLE;
                end
            end
            S_RESP: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        cctl            = '0;
        sctl            = '0;
        out_load        = 1'b0;
        sctl.full       = tbl_full;
        sctl.load_valid = (i_cmd.mode == MODE_ADD);
        i_cmd.ready     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                i_cmd.ready = 1'b1;
                sctl.load   = accept;
            end
            S_SCAN: begin
                sctl.scan = 1'b1;
                cctl.pop  = 1'b1;
                cctl.push = emit;
            end
            S_RUN: begin
                sctl.step = 1'b1;
                cctl.pop  = 1'b1;
                cctl.push = emit;
            end
            S_FLUSH: begin
                sctl.flush = 1'b1;
                cctl.push  = emit;
            end
            S_DUMP: begin
                cctl.pop  = slot_free;
                cctl.push = slot_free;
                out_load  = slot_free;
            end
            S_RESP: out_load = slot_free;
            default: ;
        endcase
    end

    assign wr_s   = (r_state == S_DUMP) ? cell_s[0] : emit_s;
    assign wr_e   = (r_state == S_DUMP) ? cell_e[0] : emit_e;
    assign wr_pos = r_occ - CNT_W'(cctl.pop);

    for (genvar g = 0; g < MAX_RANGES; g++) begin : g_cell
        logic [CODE_BITS-1:0] nxt_s;
        logic [CODE_BITS:0]   nxt_e;
        if (g == MAX_RANGES - 1) begin : g_tail
            assign nxt_s = '0;
            assign nxt_e = '0;
        end else begin : g_link
            assign nxt_s = cell_s[g+1];
            assign nxt_e = cell_e[g+1];
        end
        isms_cell #(
            .IDX    (g),
            .IDX_W  (IDX_W),
            .CODE_W (CODE_BITS)
        ) u_cell (
            .i_clk    (i_clk),
            .i_ctl    (cctl),
            .i_wr_idx (wr_pos[IDX_W-1:0]),
            .i_wr_s   (wr_s),
            .i_wr_e   (wr_e),
            .i_nxt_s  (nxt_s),
            .i_nxt_e  (nxt_e),
            .o_s      (cell_s[g]),
            .o_e      (cell_e[g])
        );
    end

    isms_stream #(
        .CODE_W (CODE_BITS)
    ) u_stream (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (sctl),
        .i_ld_s     (ld_lo),
        .i_ld_e     (ld_hi),
        .i_ld_point (cmd_pt),
        .i_x_s      (cell_s[0]),
        .i_x_e      (cell_e[0]),
        .o_emit     (emit),
        .o_emit_s   (emit_s),
        .o_emit_e   (emit_e),
        .o_st       (sst)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_rd    <= '0;
            r_occ   <= '0;
            r_wr    <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_rd  <= r_cnt;
                r_occ <= r_cnt;
                r_wr  <= '0;
            end else begin
                // A full table with an overlap goes round a second time to merge.
                if (r_state == S_SCAN && last_rd) begin
                    r_rd <= r_cnt;
                end else if (cctl.pop) begin
                    r_rd <= r_rd - 1'b1;
                end
                r_occ <= r_occ - CNT_W'(cctl.pop) + CNT_W'(cctl.push);
                if (cctl.push && (r_state == S_RUN || r_state == S_FLUSH)) begin
                    r_wr <= r_wr + 1'b1;
                end
                if (r_state == S_FLUSH) begin
                    r_cnt <= r_wr + CNT_W'(emit);
                end
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode   <= i_cmd.mode;
            r_status <= ST_OK;
        end else if (r_state == S_SCAN && last_rd && !sst.hit) begin
            r_status <= ST_FULL;
        end else if (r_state == S_FLUSH && r_mode == MODE_REMOVE) begin
            if (!sst.found) begin
                r_status <= ST_ABSENT;
            end else if (sst.split_full) begin
                r_status <= ST_FULL;
            end
        end
        if (out_load) begin
            r_o_count <= 5'(r_cnt);
            if (r_state == S_DUMP) begin
                r_o_status <= ST_OK;
                r_o_s      <= 16'(cell_s[0]);
                r_o_e      <= 17'(cell_e[0]);
                r_o_rv     <= 1'b1;
                r_o_last   <= last_rd;
            end else begin
                r_o_status <= r_status;
                r_o_s      <= '0;
                r_o_e      <= '0;
                r_o_rv     <= 1'b0;
                r_o_last   <= 1'b1;
            end
        end
    end

    assign o_res.valid       = r_ov;
    assign o_res.status      = r_o_status;
    assign o_res.entry_count = r_o_count;
    assign o_res.out_start   = r_o_s;
    assign o_res.out_end     = r_o_e;
    assign o_res.out_valid   = r_o_rv;
    assign o_res.last        = r_o_last;
endmodule
`default_nettype wire

@@ design/isms_cell.sv @@
// One table cell: holds a range, shifts toward the head or takes a written range.
`timescale 1ns / 1ps
`default_nettype none
module isms_cell #(
    parameter int IDX    = 0,
    parameter int IDX_W  = 4,
    parameter int CODE_W = 16
) (
    input  wire                    i_clk,
    input  wire isms_pkg::t_cell_ctl i_ctl,
    input  wire [IDX_W-1:0]        i_wr_idx,
    input  wire [CODE_W-1:0]       i_wr_s,
    input  wire [CODE_W:0]         i_wr_e,
    input  wire [CODE_W-1:0]       i_nxt_s,
    input  wire [CODE_W:0]         i_nxt_e,
    output logic [CODE_W-1:0]      o_s,
    output logic [CODE_W:0]        o_e
);
    import isms_pkg::*;

    logic [CODE_W-1:0] r_s;
    logic [CODE_W:0]   r_e;
    logic              wr_hit;

    assign wr_hit = i_ctl.push && (i_wr_idx == IDX_W'(IDX));

    always_ff @(posedge i_clk) begin
        if (wr_hit) begin
            r_s <= i_wr_s;
            r_e <= i_wr_e;
        end else if (i_ctl.pop) begin
            r_s <= i_nxt_s;
            r_e <= i_nxt_e;
        end
    end

    assign o_s = r_s;
    assign o_e = r_e;
endmodule
`default_nettype wire

@@ design/isms_stream.sv @@
// Edit unit at the head of the cell row: merges, trims or splits the passing ranges.
`timescale 1ns / 1ps
`default_nettype none
module isms_stream #(
    parameter int CODE_W = 16
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire isms_pkg::t_stream_ctl i_ctl,
    input  wire [CODE_W-1:0]           i_ld_s,
    input  wire [CODE_W:0]             i_ld_e,
    input  wire [CODE_W-1:0]           i_ld_point,
    input  wire [CODE_W-1:0]           i_x_s,
    input  wire [CODE_W:0]             i_x_e,
    output logic                       o_emit,
    output logic [CODE_W-1:0]          o_emit_s,
    output logic [CODE_W:0]            o_emit_e,
    output isms_pkg::t_stream_st       o_st
);
    import isms_pkg::*;

    logic              r_cv, n_cv;
    logic [CODE_W-1:0] r_cs, n_cs;
    logic [CODE_W:0]   r_ce, n_ce;
    logic [CODE_W-1:0] r_pt;
    logic              r_done, n_done;
    logic              r_sfull, n_sfull;
    logic              r_hit, n_hit;
    logic              x_before, x_touch, pt_in;
    logic [CODE_W:0]   pt_ext, xs_ext, cs_ext;

    assign pt_ext   = {1'b0, r_pt};
    assign xs_ext   = {1'b0, i_x_s};
    assign cs_ext   = {1'b0, r_cs};
    assign x_before = i_x_e < cs_ext;
    assign x_touch  = !x_before && (xs_ext <= r_ce);
    assign pt_in    = (r_pt >= i_x_s) && (pt_ext < i_x_e);

    always_comb begin
        n_cv     = r_cv;
        n_cs     = r_cs;
        n_ce     = r_ce;
        n_done   = r_done;
        n_sfull  = r_sfull;
        n_hit    = r_hit;
        o_emit   = 1'b0;
        o_emit_s = i_x_s;
        o_emit_e = i_x_e;
        if (i_ctl.load) begin
            n_cv    = i_ctl.load_valid;
            n_cs    = i_ld_s;
            n_ce    = i_ld_e;
            n_done  = 1'b0;
            n_sfull = 1'b0;
            n_hit   = 1'b0;
        end else if (i_ctl.scan) begin
            o_emit = 1'b1;
            if (x_touch) begin
                n_hit = 1'b1;
            end
        end else if (i_ctl.step) begin
            if (r_cv) begin
                if (x_before) begin
                    o_emit = 1'b1;
                end else if (x_touch) begin
                    n_cs = (i_x_s < r_cs) ? i_x_s : r_cs;
                    n_ce = (i_x_e > r_ce) ? i_x_e : r_ce;
                end else begin
                    o_emit   = 1'b1;
                    o_emit_s = r_cs;
                    o_emit_e = r_ce;
                    n_cs     = i_x_s;
                    n_ce     = i_x_e;
                end
            end else if (!r_done && pt_in) begin
                n_done = 1'b1;
                if (r_pt == i_x_s) begin
                    // A single-point range vanishes; otherwise its start moves up.
                    if (xs_ext + 1'b1 != i_x_e) begin
                        o_emit   = 1'b1;
                        o_emit_s = r_pt + 1'b1;
                    end
                end else if (pt_ext + 1'b1 == i_x_e) begin
                    o_emit   = 1'b1;
                    o_emit_e = pt_ext;
                end else if (i_ctl.full) begin
                    o_emit  = 1'b1;
                    n_sfull = 1'b1;
                end else begin
                    o_emit   = 1'b1;
                    o_emit_e = pt_ext;
                    n_cv     = 1'b1;
                    n_cs     = r_pt + 1'b1;
                    n_ce     = i_x_e;
                end
            end else begin
                o_emit = 1'b1;
            end
        end else if (i_ctl.flush) begin
            o_emit   = r_cv;
            o_emit_s = r_cs;
            o_emit_e = r_ce;
            n_cv     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv    <= 1'b0;
            r_done  <= 1'b0;
            r_sfull <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            r_cv    <= n_cv;
            r_done  <= n_done;
            r_sfull <= n_sfull;
            r_hit   <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cs <= n_cs;
        r_ce <= n_ce;
        if (i_ctl.load) begin
            r_pt <= i_ld_point;
        end
    end

    assign o_st.found      = n_done;
    assign o_st.split_full = n_sfull;
    assign o_st.hit        = n_hit;
endmodule
`default_nettype wire

@@ design/isms_checker.sv @@
// Port-level checker for the interval set block, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none
`include "interval_set_merge_split_defines.svh"
module isms_checker #(
    parameter int MAX_RANGES = 16
) (
    input wire         i_clk,
    input wire         i_rst_n,
    isms_cmd_if.sink   i_cmd,
    isms_res_if.source o_res
);
    // Only dumped ranges may be followed by more results of the same item.
    `ISMS_ASSERT_IMP(a_notlast_is_range, o_res.valid && !o_res.last, o_res.out_valid)
    `ISMS_ASSERT_IMP(a_empty_fields_zero, o_res.valid && !o_res.out_valid,
                     o_res.out_start == 16'd0 && o_res.out_end == 17'd0)
    `ISMS_ASSERT_IMP(a_count_bound, o_res.valid, int'(o_res.entry_count) <= MAX_RANGES)
    // The command channel is never ready in the cycle after an accept.
    `ISMS_ASSERT_NXT(a_one_at_a_time, i_cmd.valid && i_cmd.ready, !i_cmd.ready)
    `ISMS_ASSERT_NXT(a_res_hold, o_res.valid && !o_res.ready,
                     o_res.valid && $stable(o_res.out_start) && $stable(o_res.last))
endmodule

bind interval_set_merge_split isms_checker #(
    .MAX_RANGES (MAX_RANGES)
) u_isms_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_cmd   (i_cmd),
    .o_res   (o_res)
);
`default_nettype wire
